// ===== src/fskgen_pkg.sv =====
package fskgen_pkg;

  // Field and register widths.
  localparam int RATE_W     = 18;
  localparam int PHASE_W    = 18;
  localparam int FMT_W      = 2;
  localparam int CHAN_CFG_W = 4;
  localparam int WORD_W     = 16;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_REGS   = 6;
  localparam int REG_IDX_W  = $clog2(CFG_REGS);
  localparam int CFG_ADDR_W = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TONE_ZERO   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TONE_ONE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FORMAT      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIG_ENDIAN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS    = 3'd5;

  localparam logic [RATE_W-1:0]     RST_SAMPLE_RATE = 18'd42000;
  localparam logic [RATE_W-1:0]     RST_TONE_ZERO   = 18'd1400;
  localparam logic [RATE_W-1:0]     RST_TONE_ONE    = 18'd2100;
  localparam logic [FMT_W-1:0]      RST_FORMAT      = 2'd3;
  localparam logic [CHAN_CFG_W-1:0] RST_CHANNELS    = 4'd1;

  // Sample format codes.
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S8  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_U16 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd3;

  // Sine table geometry. Only a quarter wave is stored.
  localparam int SINE_ENTRIES = 1024;
  localparam int IDX_W        = $clog2(SINE_ENTRIES);
  localparam int QUARTER      = SINE_ENTRIES / 4;
  localparam int Q_W          = $clog2(QUARTER);
  localparam int QOFF_SHIFT   = 16 - Q_W;
  localparam int MAG_W        = 15;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = $clog2(MAX_CHANNELS + 1);

  // Divider steps: the phase bits give the remainder, the index bits follow.
  localparam int DIV_STEPS = PHASE_W + IDX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598675;
  localparam logic [63:0] POLY_C5 = 64'd85569306;
  localparam logic [63:0] POLY_C7 = 64'd5026992;

  typedef logic [MAG_W-1:0] qsine_tbl_t [QUARTER];

  // sin(pi/2 * z) for z in Q16, returned as a Q15 magnitude.
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] z);
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] v;
    z2 = (z * z) >> 16;
    p  = POLY_C7;
    p  = POLY_C5 - ((p * z2) >> 16);
    p  = POLY_C3 - ((p * z2) >> 16);
    p  = POLY_C1 - ((p * z2) >> 16);
    v  = (p * z) >> 16;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic qsine_tbl_t build_qsine();
    qsine_tbl_t t;
    for (int k = 0; k < QUARTER; k++) begin
      t[k] = quarter_sine(64'(k) << QOFF_SHIFT);
    end
    return t;
  endfunction

  localparam qsine_tbl_t       QSINE_TBL = build_qsine();
  localparam logic [MAG_W-1:0] QS_FULL   = quarter_sine(64'd65536);

endpackage

// ===== src/fskgen_if.sv =====
interface fskgen_in_if import fskgen_pkg::*; ();
  logic valid;
  logic ready;
  logic tone_select;

  modport source (output valid, output tone_select, input ready);
  modport sink (input valid, input tone_select, output ready);
endinterface

interface fskgen_out_if import fskgen_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] sample_word;
  logic              last_channel;

  modport source (output valid, output sample_word, output last_channel, input ready);
  modport sink (input valid, input sample_word, input last_channel, output ready);
endinterface

// ===== src/fsk_tone_sample_generator_unit.sv =====
// Channel   Direction  Carries
// in_if     sink       one sample tick: tone_select
// out_if    source     one channel copy: sample_word, last_channel
// APB       slave      six configuration registers at byte addresses 0..20
//
// An item yields n copies, n being the effective channel count, and the next item can
// be accepted in the cycle after its last copy is taken. A 28-step restoring divider,
// one quotient bit per cycle, reduces the phase by the sample rate and then yields
// the ten table index bits. Reset is synchronous and active low; it restores register
// defaults and clears both tone phases. A stall on out_if holds the current copy;
// in_if waits for the last one.
module fsk_tone_sample_generator_unit import fskgen_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fskgen_in_if.sink             in_if,
  fskgen_out_if.source          out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_LOOK = 5'b00100,
    ST_FMT  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Configuration registers.
  logic [RATE_W-1:0]     cfg_rate_r;
  logic [RATE_W-1:0]     cfg_tone0_r;
  logic [RATE_W-1:0]     cfg_tone1_r;
  logic [FMT_W-1:0]      cfg_fmt_r;
  logic                  cfg_swap_r;
  logic [CHAN_CFG_W-1:0] cfg_chan_r;

  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  cfg_idx;

  state_t                state_r;
  logic [PHASE_W-1:0]    phase_zero_r;
  logic [PHASE_W-1:0]    phase_one_r;

  // Per-item working registers.
  logic                  sel_r;
  logic [RATE_W-1:0]     rate_r;
  logic [RATE_W-1:0]     fcl_r;
  logic [PHASE_W-1:0]    dvd_r;
  logic [RATE_W-1:0]     rem_r;
  logic [IDX_W-1:0]      quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [RATE_W-1:0]     p_r;
  logic [RATE_W:0]       sum_r;
  logic [MAG_W-1:0]      m_r;
  logic                  neg_r;
  logic [WORD_W-1:0]     word_r;
  logic [CH_W-1:0]       n_r;
  logic [CH_W-1:0]       ch_r;

  logic                  in_acc;
  logic                  out_acc;
  logic                  last_copy;

  logic [RATE_W-1:0]     rate_eff;
  logic [RATE_W-1:0]     f_sel;
  logic [RATE_W-1:0]     f_clamped;
  logic [CH_W-1:0]       n_eff;

  logic [RATE_W:0]       rem_sh;
  logic [RATE_W:0]       rem_diff;
  logic                  qbit;
  logic [RATE_W-1:0]     rem_step;

  logic [1:0]            quad;
  logic [Q_W-1:0]        qk;
  logic [Q_W-1:0]        tidx;
  logic                  use_full;

  logic [RATE_W-1:0]     phase_new;

  logic [WORD_W-1:0]     off;
  logic [23:0]           u8_prod;
  logic [21:0]           s8_prod;
  logic [7:0]            s8_t;
  logic [7:0]            s8_word;
  logic [WORD_W-1:0]     u16_word;
  logic [WORD_W-1:0]     s16_t;
  logic [WORD_W-1:0]     s16_word;
  logic [WORD_W-1:0]     w16;
  logic [WORD_W-1:0]     fmt_word;

  // ---------------------------------------------------------------------------
  // APB register file. Writes complete in the access phase; pready is tied high.
  // Register i sits at byte address 4*i, and addresses past the list are ignored.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rate_r  <= RST_SAMPLE_RATE;
      cfg_tone0_r <= RST_TONE_ZERO;
      cfg_tone1_r <= RST_TONE_ONE;
      cfg_fmt_r   <= RST_FORMAT;
      cfg_swap_r  <= 1'b0;
      cfg_chan_r  <= RST_CHANNELS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SAMPLE_RATE: cfg_rate_r  <= pwdata[RATE_W-1:0];
        REG_TONE_ZERO:   cfg_tone0_r <= pwdata[RATE_W-1:0];
        REG_TONE_ONE:    cfg_tone1_r <= pwdata[RATE_W-1:0];
        REG_FORMAT:      cfg_fmt_r   <= pwdata[FMT_W-1:0];
        REG_BIG_ENDIAN:  cfg_swap_r  <= pwdata[0];
        REG_CHANNELS:    cfg_chan_r  <= pwdata[CHAN_CFG_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SAMPLE_RATE: prdata = CFG_DATA_W'(cfg_rate_r);
      REG_TONE_ZERO:   prdata = CFG_DATA_W'(cfg_tone0_r);
      REG_TONE_ONE:    prdata = CFG_DATA_W'(cfg_tone1_r);
      REG_FORMAT:      prdata = CFG_DATA_W'(cfg_fmt_r);
      REG_BIG_ENDIAN:  prdata = CFG_DATA_W'(cfg_swap_r);
      REG_CHANNELS:    prdata = CFG_DATA_W'(cfg_chan_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshakes. One tick is in flight at a time; its copies come straight from
  // the formatted word register.
  // ---------------------------------------------------------------------------
  assign in_if.ready         = (state_r == ST_IDLE);
  assign in_acc              = in_if.valid & in_if.ready;
  assign out_if.valid        = (state_r == ST_EMIT);
  assign out_if.sample_word  = word_r;
  assign last_copy           = (ch_r == n_r - 1'b1);
  assign out_if.last_channel = last_copy;
  assign out_acc             = out_if.valid & out_if.ready;

  // ---------------------------------------------------------------------------
  // Values captured when a tick is accepted. A zero rate behaves as one, a tone
  // at or above the rate is pulled down to rate-1, and the channel count is
  // limited to the range one through MAX_CHANNELS.
  // ---------------------------------------------------------------------------
  assign rate_eff  = (cfg_rate_r == '0) ? RATE_W'(1) : cfg_rate_r;
  assign f_sel     = in_if.tone_select ? cfg_tone1_r : cfg_tone0_r;
  assign f_clamped = (f_sel >= rate_eff) ? (rate_eff - 1'b1) : f_sel;

  always_comb begin
    if (cfg_chan_r == '0) begin
      n_eff = CH_W'(1);
    end else if (32'(cfg_chan_r) > MAX_CHANNELS) begin
      n_eff = CH_W'(MAX_CHANNELS);
    end else begin
      n_eff = CH_W'(cfg_chan_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per cycle. The dividend is the stored
  // phase followed by IDX_W zero bits. After the phase bits have been shifted in,
  // the partial remainder is the phase reduced modulo the rate; the quotient bits
  // produced over the remaining steps form floor(reduced phase * SINE_ENTRIES / rate).
  // Because the reduced phase is below the rate, that index always fits.
  // ---------------------------------------------------------------------------
  assign rem_sh   = {rem_r, dvd_r[PHASE_W-1]};
  assign rem_diff = rem_sh - {1'b0, rate_r};
  assign qbit     = ~rem_diff[RATE_W];
  assign rem_step = qbit ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];

  // ---------------------------------------------------------------------------
  // Quarter-wave lookup. Odd quadrants read the table mirrored; the mirror of
  // offset zero is the quarter-turn value, which lies one past the stored table.
  // The upper half of the turn is negated.
  // ---------------------------------------------------------------------------
  assign quad     = quo_r[IDX_W-1 -: 2];
  assign qk       = quo_r[Q_W-1:0];
  assign use_full = quad[0] && (qk == '0);
  assign tidx     = quad[0] ? Q_W'(QUARTER - 32'(qk)) : qk;

  // Phase advance: the sum of two values below the rate needs one subtract.
  assign phase_new = (sum_r >= {1'b0, rate_r}) ? RATE_W'(sum_r - {1'b0, rate_r})
                                               : sum_r[RATE_W-1:0];

  // ---------------------------------------------------------------------------
  // Sample formatting. The table magnitude is at most 32767, so the signed value
  // is neg_r with magnitude m_r. The scale factors are all of the form 2^k - 1,
  // so each product is a shift and a subtract.
  // ---------------------------------------------------------------------------
  assign off      = neg_r ? (16'h8000 - {1'b0, m_r}) : {1'b1, m_r};
  assign u8_prod  = {off, 8'h00} - {8'h00, off};
  assign s8_prod  = {m_r, 7'b0} - {7'b0, m_r};
  assign s8_t     = {1'b0, s8_prod[21:15]};
  assign s8_word  = neg_r ? (8'h00 - s8_t) : s8_t;
  assign u16_word = (off == '0) ? '0 : (off - 1'b1);
  assign s16_t    = (m_r == '0) ? '0 : ({1'b0, m_r} - 1'b1);
  assign s16_word = neg_r ? (16'h0000 - s16_t) : s16_t;

  always_comb begin
    unique case (cfg_fmt_r)
      FMT_U8:  begin
        w16      = u16_word;
        fmt_word = {8'h00, u8_prod[23:16]};
      end
      FMT_S8:  begin
        w16      = s16_word;
        fmt_word = {8'h00, s8_word};
      end
      FMT_U16: begin
        w16      = u16_word;
        fmt_word = cfg_swap_r ? {w16[7:0], w16[15:8]} : w16;
      end
      default: begin
        w16      = s16_word;
        fmt_word = cfg_swap_r ? {w16[7:0], w16[15:8]} : w16;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_zero_r <= '0;
      phase_one_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_r <= ST_FMT;
        end
        ST_FMT: begin
          if (sel_r) begin
            phase_one_r <= PHASE_W'(phase_new);
          end else begin
            phase_zero_r <= PHASE_W'(phase_new);
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_acc && last_copy) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers carry no reset; each is loaded before it is read.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sel_r  <= in_if.tone_select;
          rate_r <= rate_eff;
          fcl_r  <= f_clamped;
          n_r    <= n_eff;
          dvd_r  <= in_if.tone_select ? phase_one_r : phase_zero_r;
          rem_r  <= '0;
          cnt_r  <= '0;
        end
      end
      ST_DIV: begin
        rem_r <= rem_step;
        dvd_r <= {dvd_r[PHASE_W-2:0], 1'b0};
        quo_r <= {quo_r[IDX_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PHASE_W - 1)) begin
          p_r <= rem_step;
        end
      end
      ST_LOOK: begin
        m_r   <= use_full ? QS_FULL : QSINE_TBL[tidx];
        neg_r <= quad[1];
        sum_r <= {1'b0, p_r} + {1'b0, fcl_r};
      end
      ST_FMT: begin
        word_r <= fmt_word;
        ch_r   <= '0;
      end
      ST_EMIT: begin
        if (out_acc && !last_copy) begin
          ch_r <= ch_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------

  // The reduced phase entering the lookup is always below the captured rate.
  a_phase_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> (p_r < rate_r))
    else $error("reduced phase not below the sample rate");

  // The phase written back for the tone that played stays below the rate.
  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FMT) |=>
      ((sel_r ? phase_one_r : phase_zero_r) < RATE_W'(rate_r)))
    else $error("advanced phase not wrapped below the sample rate");

  // Taking the final copy of a tick makes the block ready for the next one.
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && last_copy) |=> in_if.ready)
    else $error("input not ready after the final copy was taken");

  // The copy index never runs past the effective channel count.
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (ch_r < n_r) && (n_r != '0) && (32'(n_r) <= MAX_CHANNELS))
    else $error("channel copy index out of range");

endmodule

// ===== tb/fsk_tone_checker.sv =====
`timescale 1ns / 1ps

// Watches both item channels and the register bus, keeps a private model of the
// tone generator, and compares every channel copy against the expected copy.
module fsk_tone_checker import fskgen_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fskgen_in_if                  in_mon,
  fskgen_out_if                 out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } copy_t;

  copy_t             copies_due[$];
  logic [WORD_W-1:0] sine_rom [SINE_ENTRIES];

  logic [RATE_W-1:0]     rate_reg;
  logic [RATE_W-1:0]     tone0_reg;
  logic [RATE_W-1:0]     tone1_reg;
  logic [FMT_W-1:0]      fmt_reg;
  logic                  swap_reg;
  logic [CHAN_CFG_W-1:0] chan_reg;
  logic [PHASE_W-1:0]    phase_zero;
  logic [PHASE_W-1:0]    phase_one;

  // Odd seventh-order polynomial for sin(pi/2 * z), z in Q16, Q15 magnitude out.
  function automatic logic [MAG_W-1:0] quarter_mag(input logic [63:0] z);
    logic [63:0] zsq;
    logic [63:0] acc;
    logic [63:0] v;
    zsq = (z * z) >> 16;
    acc = POLY_C5 - ((POLY_C7 * zsq) >> 16);
    acc = POLY_C3 - ((acc * zsq) >> 16);
    acc = POLY_C1 - ((acc * zsq) >> 16);
    v = ((acc * z) >> 16) + 64'd16384;
    v = v >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] rom_value(input int i);
    logic [63:0]      u;
    logic [63:0]      r;
    int               quad;
    logic [MAG_W-1:0] m;
    logic [31:0]      neg;
    u    = (64'(i) << 18) / 64'(SINE_ENTRIES);
    quad = int'(u >> 16) & 3;
    r    = u & 64'hFFFF;
    if (quad == 0 || quad == 2) begin
      m = quarter_mag(r);
    end else begin
      m = quarter_mag(64'd65536 - r);
    end
    neg = 32'h10000 - 32'(m);
    return (quad >= 2) ? neg[WORD_W-1:0] : WORD_W'(m);
  endfunction

  // Converts a Q1.15 table value into the selected sample format.
  function automatic logic [WORD_W-1:0] format_word(input logic [WORD_W-1:0] raw);
    longint            s;
    longint            mag;
    longint            off;
    longint            t;
    logic [WORD_W-1:0] w;
    s   = longint'($signed(raw));
    mag = (s < 0) ? -s : s;
    off = 32768 + s;
    case (fmt_reg)
      FMT_U8: begin
        return WORD_W'((off * 255) >>> 16);
      end
      FMT_S8: begin
        t = (mag * 127) >>> 15;
        return WORD_W'(((s < 0) ? (256 - t) : t) & 255);
      end
      FMT_U16: begin
        w = WORD_W'((off * 65535) >>> 16);
      end
      default: begin
        t = (mag * 32767) >>> 15;
        w = WORD_W'((s < 0) ? (65536 - t) : t);
      end
    endcase
    if (swap_reg) begin
      w = {w[7:0], w[15:8]};
    end
    return w;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 50) begin
      $display("[%0t] fsk sample mismatch: %s", $time, msg);
    end
  endtask

  // Works out the copies one tick produces and advances the phase of its tone.
  task automatic play_tick(input logic sel);
    logic [31:0]       rate;
    logic [31:0]       step;
    logic [31:0]       ph;
    logic [31:0]       idx;
    logic [WORD_W-1:0] w;
    int                n;
    rate = (rate_reg == '0) ? 32'd1 : 32'(rate_reg);
    step = sel ? 32'(tone1_reg) : 32'(tone0_reg);
    if (step > rate - 1) begin
      step = rate - 1;
    end
    ph  = (sel ? 32'(phase_one) : 32'(phase_zero)) % rate;
    idx = 32'((64'(ph) * 64'(SINE_ENTRIES)) / 64'(rate));
    if (idx >= 32'(SINE_ENTRIES)) begin
      idx = 32'(SINE_ENTRIES - 1);
    end
    w  = format_word(sine_rom[idx]);
    ph = ph + step;
    if (ph >= rate) begin
      ph = ph - rate;
    end
    if (sel) begin
      phase_one = PHASE_W'(ph);
    end else begin
      phase_zero = PHASE_W'(ph);
    end
    if (chan_reg == '0) begin
      n = 1;
    end else if (int'(chan_reg) > MAX_CHANNELS) begin
      n = MAX_CHANNELS;
    end else begin
      n = int'(chan_reg);
    end
    for (int k = 0; k < n; k++) begin
      copies_due.push_back('{word: w, last: (k == n - 1)});
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      sine_rom[i] = rom_value(i);
    end
  end

  always @(posedge clk) begin : watch
    copy_t due;
    if (!rst_n) begin
      rate_reg   = RST_SAMPLE_RATE;
      tone0_reg  = RST_TONE_ZERO;
      tone1_reg  = RST_TONE_ONE;
      fmt_reg    = RST_FORMAT;
      swap_reg   = 1'b0;
      chan_reg   = RST_CHANNELS;
      phase_zero = '0;
      phase_one  = '0;
      copies_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (copies_due.size() == 0) begin
          report($sformatf("copy %h last %b arrived with none pending",
                           out_mon.sample_word, out_mon.last_channel));
        end else begin
          due = copies_due.pop_front();
          if (out_mon.sample_word !== due.word) begin
            report($sformatf("sample_word %h, predicted %h", out_mon.sample_word, due.word));
          end
          if (out_mon.last_channel !== due.last) begin
            report($sformatf("last_channel %b, predicted %b", out_mon.last_channel, due.last));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        play_tick(in_mon.tone_select);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_SAMPLE_RATE: rate_reg  = pwdata[RATE_W-1:0];
          REG_TONE_ZERO:   tone0_reg = pwdata[RATE_W-1:0];
          REG_TONE_ONE:    tone1_reg = pwdata[RATE_W-1:0];
          REG_FORMAT:      fmt_reg   = pwdata[FMT_W-1:0];
          REG_BIG_ENDIAN:  swap_reg  = pwdata[0];
          REG_CHANNELS:    chan_reg  = pwdata[CHAN_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = copies_due.size();
  end

endmodule

// ===== tb/fsk_tone_sample_generator_unit_tb.sv =====
`timescale 1ns / 1ps

// Top of the tone generator testbench. This module only makes stimulus and gives
// the verdict: the checker beside the block predicts and compares every copy.
module fsk_tone_sample_generator_unit_tb;
  import fskgen_pkg::*;

  // Addresses past the six registers. Writes there must leave everything alone.
  localparam int REG_SPARE_A = CFG_REGS;
  localparam int REG_SPARE_B = CFG_REGS + 1;

  // A correct block never goes this long without some handshake, even with the
  // longest output stall landing on the widest tick.
  localparam int STALL_LIMIT = 2000;

  // Ticks generated in the random part.
  localparam int RANDOM_TICKS = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic        sink_ready = 1'b0;
  int          ready_hold = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  int unsigned mismatches;
  int unsigned outstanding;

  fskgen_in_if  in_ch ();
  fskgen_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  fsk_tone_sample_generator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fsk_tone_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Length of one idle stretch: mostly short, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Fills the bits above a register's width with junk now and then, so that the
  // block is seen to ignore them.
  function automatic logic [CFG_DATA_W-1:0] noisy(input logic [31:0] v, input int width);
    if ($urandom_range(0, 3) == 0) begin
      return ($urandom << width) | v;
    end
    return v;
  endfunction

  // Tone frequencies: mostly below the rate, sometimes zero, sometimes anything
  // the 18-bit field holds so that clamping gets exercised.
  function automatic logic [31:0] pick_tone(input logic [31:0] rate);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 262143);
      1: return 0;
      default: return (rate < 2) ? 0 : $urandom_range(1, rate - 1);
    endcase
  endfunction

  // Result side back-pressure. Outside calm stretches the receiver drops ready
  // at random, so stalls hit the first copy, middle copies and the last one.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      sink_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      ready_hold = pause_len() - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Watchdog: any handshake on either channel or a register write restarts it.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("fsk_tone_sample_generator_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One register write: a setup phase, then the access phase that commits it.
  // Called right after a falling edge and returns right after one.
  task automatic cfg_write(input int idx, input logic [CFG_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'(idx << 2);
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Offers one sample tick, after an optional idle gap, and waits for acceptance.
  // valid stays high after the handshake so back-to-back ticks need no bubble.
  task automatic send_tick(input logic sel);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      in_ch.valid       = 1'b0;
      in_ch.tone_select = $urandom_range(0, 1);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.tone_select = sel;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Registers may only change while the block is idle, that is once every
  // expected copy has been taken; the input side is then not busy either.
  task automatic await_idle();
    in_ch.valid = 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
  endtask

  // A random register setting. Rates favor tiny values, where the table peaks
  // and the phase wrap come up often, but zero and the top of the field occur.
  task automatic random_setup();
    logic [31:0] rate;
    case ($urandom_range(0, 9))
      0:       rate = 0;
      1, 2, 3: rate = $urandom_range(1, 16);
      4:       rate = 192000;
      5:       rate = $urandom_range(192001, 262143);
      default: rate = $urandom_range(1000, 96000);
    endcase
    cfg_write(REG_SAMPLE_RATE, noisy(rate, RATE_W));
    cfg_write(REG_TONE_ZERO, noisy(pick_tone(rate), RATE_W));
    cfg_write(REG_TONE_ONE, noisy(pick_tone(rate), RATE_W));
    cfg_write(REG_FORMAT, noisy($urandom_range(0, 3), FMT_W));
    cfg_write(REG_BIG_ENDIAN, noisy($urandom_range(0, 1), 1));
    cfg_write(REG_CHANNELS, noisy($urandom_range(0, 15), CHAN_CFG_W));
    if ($urandom_range(0, 4) == 0) begin
      cfg_write($urandom_range(REG_SPARE_A, REG_SPARE_B), $urandom);
    end
    calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int sent;
    int run;
    logic sel;

    in_ch.valid       = 1'b0;
    in_ch.tone_select = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: signed 16-bit, one channel, 1400 and 2100 Hz at 42 kHz.
    // Both tones play, each advancing only its own phase.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    await_idle();

    // A rate of four, written with junk above the field. Tone zero steps one
    // quarter wave per tick and tone one three quarters, so both reach the
    // positive and negative peaks. The old phases exceed the new rate and must
    // be reduced first. A channel count of zero acts as one. The spare
    // addresses take writes that must change nothing.
    cfg_write(REG_SAMPLE_RATE, 32'hFFFC_0004);
    cfg_write(REG_TONE_ZERO, 32'd1);
    cfg_write(REG_TONE_ONE, 32'd3);
    cfg_write(REG_FORMAT, FMT_U16);
    cfg_write(REG_BIG_ENDIAN, 32'd0);
    cfg_write(REG_CHANNELS, 32'd0);
    cfg_write(REG_SPARE_A, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_B, 32'hFFFF_FFFF);
    repeat (4) send_tick(1'b0);
    repeat (4) send_tick(1'b1);
    await_idle();

    // A rate of zero acts as one, so both tones are clamped to zero. Byte swap
    // is set but has no effect on an 8-bit format; a channel count above the
    // maximum saturates.
    cfg_write(REG_SAMPLE_RATE, 32'd0);
    cfg_write(REG_TONE_ZERO, 32'd191999);
    cfg_write(REG_FORMAT, FMT_U8);
    cfg_write(REG_BIG_ENDIAN, 32'd1);
    cfg_write(REG_CHANNELS, 32'd15);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    await_idle();

    // A rate of 192000 with the largest legal tone, and a quarter-rate tone that
    // lands on the peaks, in signed 8-bit with all eight channels.
    cfg_write(REG_SAMPLE_RATE, 32'd192000);
    cfg_write(REG_TONE_ZERO, 32'd48000);
    cfg_write(REG_TONE_ONE, 32'd191999);
    cfg_write(REG_FORMAT, FMT_S8);
    cfg_write(REG_CHANNELS, 32'd8);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    await_idle();

    // Random part: each phase picks a setting, then plays FSK symbols as runs
    // of the same bit, the way a modulator is fed.
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      random_setup();
      run = $urandom_range(8, 20);
      while (run > 0) begin
        sel = $urandom_range(0, 1);
        repeat ($urandom_range(1, 6)) begin
          if (run > 0) begin
            send_tick(sel);
            run--;
            sent++;
          end
        end
      end
      await_idle();
    end

    // Everything predicted has arrived. Leave room for any stray copy.
    calm = 1'b0;
    repeat (48) @(negedge clk);
    if (mismatches == 0) begin
      $display("fsk_tone_sample_generator_unit verification clean");
    end else begin
      $display("fsk_tone_sample_generator_unit verification failed");
    end
    $finish;
  end

endmodule
